// ===== hdl/lru_tag_cache_defines.svh =====
// ----------------------------------------------------------------------------
// lru_tag_cache_defines.svh
// Assertion macros for the LRU tag cache. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef LRU_TAG_CACHE_DEFINES_SVH
`define LRU_TAG_CACHE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define LRUTC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lru_tag_cache: invariant violated");

// Check that a condition implies another in the same cycle.
`define LRUTC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lru_tag_cache: implication violated");

`else

`define LRUTC_ASSERT(lbl, prop)
`define LRUTC_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== hdl/lrutc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrutc_pkg
// Shared constants, command codes and controller states of the LRU tag cache.
// ----------------------------------------------------------------------------
package lrutc_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TAG_W       = 64;
   localparam int CMD_W       = 2;
   localparam int EVICT_W     = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_EVICT = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_RESP,
      ST_EV_READ,
      ST_EV_OUT
   } state_type;

endpackage

// ===== hdl/lrutc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// lrutc_tag_ram
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrutc_tag_ram #(
   parameter int DEPTH = lrutc_pkg::ENTRIES_DEF,
   parameter int WIDTH = 2 * lrutc_pkg::TAG_W
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lru_tag_cache.sv =====
// ----------------------------------------------------------------------------
// lru_tag_cache
// Fully associative LRU table of pointer/hash tags with add, probe and evict.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | command, pointer, hash, count
//   rsp     | out       | rsp_valid/rsp_stall  | hit, evicted ptr, valid, last
//
//   Add and probe walk the single tag RAM read port one entry per cycle,
//   then decide, then load the result word. Evict accepts the request,
//   then for each removed entry does the victim lookup and RAM read, then
//   the output; when nothing is removed it loads one empty result word.
//   Reset is synchronous; it clears occupancy, ranks and control, not tags.
//   A result word waits in the output register under rsp_stall while the
//   next request word is accepted; req_stall is high while one is in work.
//
`include "lru_tag_cache_defines.svh"

module lru_tag_cache #(
   parameter int ENTRIES = lrutc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrutc_pkg::CMD_W-1:0]   req_command,
   input  logic [lrutc_pkg::TAG_W-1:0]   req_entry_pointer,
   input  logic [lrutc_pkg::TAG_W-1:0]   req_entry_hash,
   input  logic [lrutc_pkg::EVICT_W-1:0] req_evict_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [lrutc_pkg::TAG_W-1:0]   rsp_evicted_pointer,
   output logic                          rsp_item_valid,
   output logic                          rsp_last
);
   import lrutc_pkg::*;

   // Slot index and rank share a width; the count must also hold ENTRIES.
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int LEFT_W = $clog2(MAX_RESULTS + 1);
   localparam int CMP_A  = (CNT_W > EVICT_W) ? CNT_W : EVICT_W;
   localparam int CMP_W  = (CMP_A > LEFT_W) ? CMP_A : LEFT_W;
   localparam int DATA_W = 2 * TAG_W;

   // Controller and request capture
   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [TAG_W-1:0]    ptr_ff, hash_ff;
   logic                req_accept;

   // Scan pipeline
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_slot_ff, found_slot_in;

   // Replacement state per slot
   logic [ENTRIES-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]    rank_ff [ENTRIES];
   logic [IDX_W-1:0]    rank_in [ENTRIES];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic                res_hit_ff, res_hit_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [TAG_W-1:0]    rsp_ptr_ff, rsp_ptr_in;
   logic                rsp_item_valid_ff, rsp_item_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free;

   // Tag RAM port
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [DATA_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [DATA_W-1:0]   ram_rd_data;

   // Derived lookups
   logic                cur_match, match_now;
   logic [IDX_W-1:0]    match_slot;
   logic [IDX_W-1:0]    hit_rank;
   logic                full;
   logic [ENTRIES-1:0]  oldest_vec, victim_vec, free_vec;
   logic [IDX_W-1:0]    victim_slot, free_slot;
   logic                victim_any, free_any;
   logic [CNT_W-1:0]    cnt_m1;
   logic [CMP_W-1:0]    take;

   lrutc_tag_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (DATA_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Compare the tag word that came back from the RAM this cycle. Only an
   // occupied slot may match, so unwritten RAM entries never matter.
   assign cur_match  = rd_vld_ff && occ_ff[rd_idx_ff] &&
                       (ram_rd_data == {ptr_ff, hash_ff});
   assign match_now  = found_ff || cur_match;
   assign match_slot = found_ff ? found_slot_ff : rd_idx_ff;
   assign hit_rank   = rank_ff[match_slot];

   assign full   = (cnt_ff == CNT_W'(ENTRIES));
   assign cnt_m1 = cnt_ff - CNT_W'(1);

   // Ranks of occupied slots are a permutation of 0..count-1, so the oldest
   // entry of a full table has the top rank and the next victim of an evict
   // always has rank count-1.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         oldest_vec[i] = occ_ff[i] && (rank_ff[i] == IDX_W'(ENTRIES - 1));
         victim_vec[i] = occ_ff[i] && (rank_ff[i] == cnt_m1[IDX_W-1:0]);
         free_vec[i]   = !(occ_ff[i] && !(full && oldest_vec[i]));
      end
   end

   // Lowest index wins.
   always_comb begin
      victim_slot = '0;
      free_slot   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (victim_vec[i]) begin
            victim_slot = IDX_W'(i);
         end
         if (free_vec[i]) begin
            free_slot = IDX_W'(i);
         end
      end
   end

   assign victim_any = |victim_vec;
   assign free_any   = |free_vec;

   // Evict length: limit to occupied entries and to one burst of results.
   always_comb begin
      take = CMP_W'(req_evict_count);
      if (CMP_W'(cnt_ff) < take) begin
         take = CMP_W'(cnt_ff);
      end
      if (CMP_W'(MAX_RESULTS) < take) begin
         take = CMP_W'(MAX_RESULTS);
      end
   end

   // Next state and datapath control
   always_comb begin
      state_in          = state_ff;
      scan_idx_in       = scan_idx_ff;
      rd_vld_in         = (state_ff == ST_SCAN);
      rd_idx_in         = scan_idx_ff;
      found_in          = found_ff;
      found_slot_in     = found_slot_ff;
      occ_in            = occ_ff;
      rank_in           = rank_ff;
      cnt_in            = cnt_ff;
      left_in           = left_ff;
      res_hit_in        = res_hit_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_hit_in        = rsp_hit_ff;
      rsp_ptr_in        = rsp_ptr_ff;
      rsp_item_valid_in = rsp_item_valid_ff;
      rsp_last_in       = rsp_last_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = free_slot;
      ram_wr_data       = {ptr_ff, hash_ff};
      ram_rd_en         = 1'b0;
      ram_rd_addr       = scan_idx_ff;

      // Record the first match seen during the walk.
      if (cur_match && !found_ff) begin
         found_in      = 1'b1;
         found_slot_in = rd_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               found_in    = 1'b0;
               scan_idx_in = '0;
               res_hit_in  = 1'b0;
               case (req_command)
                  CMD_ADD, CMD_PROBE: begin
                     state_in = ST_SCAN;
                  end
                  CMD_EVICT: begin
                     left_in = LEFT_W'(take);
                     if (take == '0) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_EV_READ;
                     end
                  end
                  default: begin
                     // Unknown command: no effect, one empty result.
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Walk every slot; each compare comes in the cycle after its read.
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_idx_ff;
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            res_hit_in = match_now;
            state_in   = ST_RESP;
            if (cmd_ff == CMD_ADD) begin
               if (match_now) begin
                  // Refresh: age everything younger, move the hit to front.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (occ_ff[i] && (rank_ff[i] < hit_rank)) begin
                        rank_in[i] = rank_ff[i] + IDX_W'(1);
                     end
                  end
                  rank_in[match_slot] = '0;
               end else begin
                  // Insert: drop the oldest when full, age the rest, fill
                  // the lowest free slot.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (!free_vec[i]) begin
                        rank_in[i] = rank_ff[i] + IDX_W'(1);
                     end
                     if (full && oldest_vec[i]) begin
                        occ_in[i] = 1'b0;
                     end
                  end
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = free_slot;
                  occ_in[free_slot]  = 1'b1;
                  rank_in[free_slot] = '0;
                  if (!full) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = res_hit_ff;
               rsp_ptr_in        = '0;
               rsp_item_valid_in = 1'b0;
               rsp_last_in       = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_EV_READ: begin
            // Remove the oldest entry and fetch its pointer.
            ram_rd_en            = 1'b1;
            ram_rd_addr          = victim_slot;
            occ_in[victim_slot]  = 1'b0;
            rank_in[victim_slot] = '0;
            cnt_in               = cnt_m1;
            left_in              = left_ff - LEFT_W'(1);
            state_in             = ST_EV_OUT;
         end

         ST_EV_OUT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = 1'b0;
               rsp_ptr_in        = ram_rd_data[DATA_W-1:TAG_W];
               rsp_item_valid_in = 1'b1;
               rsp_last_in       = (left_ff == '0);
               if (left_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EV_READ;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rank_ff      <= '{default: '0};
         cnt_ff       <= '0;
         left_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rank_ff      <= rank_in;
         cnt_ff       <= cnt_in;
         left_ff      <= left_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= req_command;
         ptr_ff  <= req_entry_pointer;
         hash_ff <= req_entry_hash;
      end
      rd_idx_ff         <= rd_idx_in;
      found_slot_ff     <= found_slot_in;
      res_hit_ff        <= res_hit_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_ptr_ff        <= rsp_ptr_in;
      rsp_item_valid_ff <= rsp_item_valid_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_evicted_pointer = rsp_ptr_ff;
   assign rsp_item_valid      = rsp_item_valid_ff;
   assign rsp_last            = rsp_last_ff;

   // Occupancy count tracks the valid bits.
   `LRUTC_ASSERT(a_cnt_tracks_occ, cnt_ff == CNT_W'($countones(occ_ff)))
   // An evict step always finds an entry of the expected age.
   `LRUTC_ASSERT_IMP(a_victim_found, state_ff == ST_EV_READ, victim_any)
   // An insert always has a slot to fill once the oldest is dropped.
   `LRUTC_ASSERT_IMP(a_free_slot, (state_ff == ST_DECIDE) && (cmd_ff == CMD_ADD) && !match_now, free_any)

endmodule
